// ===== rtl/sbctp_pkg.sv =====
// Package for the six-bit codebook text packer.
// Holds the item structs, command codes, register indexes and fixed codes.
// No dependencies.
package sbctp_pkg;

  localparam int BOOK_ENTRIES = 64;
  localparam int BOOK_AW      = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  localparam logic [5:0] ESC_CODE     = 6'd50;
  localparam logic [5:0] MISS_CODE    = 6'd52;
  localparam logic [7:0] MISS_CHAR    = 8'd32;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] BRACKET_CHAR = 8'd93;
  localparam logic [7:0] UPPER_LO     = 8'd65;
  localparam logic [7:0] UPPER_HI     = 8'd90;

  localparam logic [CFG_IDX_W-1:0] REG_CB_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPAND  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] entry_index;
    logic [7:0] entry_char;
    logic [5:0] entry_code;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic [BOOK_AW-1:0] idx;
    logic [7:0]         chr;
    logic [5:0]         code;
  } book_wr_t;

  typedef struct packed {
    logic       start;
    logic       reverse;
    logic [7:0] key;
  } srch_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
  } srch_rsp_t;

endpackage

// ===== rtl/sbctp_search.sv =====
// Codebook store and sequential search engine, one entry compared per cycle.
// Forward search maps a character to a code, reverse maps a code to a character.
// Depends on sbctp_pkg.
module sbctp_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          cb_size_i,
  input  sbctp_pkg::book_wr_t wr_i,
  input  sbctp_pkg::srch_req_t req_i,
  output sbctp_pkg::srch_rsp_t rsp_o
);
  import sbctp_pkg::*;

  typedef enum logic [1:0] {
    SR_IDLE = 2'b01,
    SR_SCAN = 2'b10
  } sr_state_e;

  sr_state_e    state_q, state_d;
  logic [6:0]   addr_q, addr_d;
  logic         rd_vld_q, rd_vld_d;
  logic         rev_q;
  logic [7:0]   key_q;
  logic [13:0]  mem [BOOK_ENTRIES];
  logic [13:0]  rd_q;
  logic [6:0]   limit;
  logic         hit;

  assign limit = (cb_size_i > 7'(BOOK_ENTRIES)) ? 7'(BOOK_ENTRIES) : cb_size_i;
  assign hit   = rd_vld_q && (rev_q ? (rd_q[5:0] == key_q[5:0]) : (rd_q[13:6] == key_q));

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.idx] <= {wr_i.chr, wr_i.code};
    end
    rd_q <= mem[addr_q[BOOK_AW-1:0]];
  end

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    rd_vld_d = 1'b0;
    rsp_o    = '0;
    case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          state_d = SR_SCAN;
          addr_d  = '0;
        end
      end
      SR_SCAN: begin
        if (hit) begin
          rsp_o.done   = 1'b1;
          rsp_o.result = rev_q ? rd_q[13:6] : {2'b00, rd_q[5:0]};
          state_d      = SR_IDLE;
        end else if (addr_q >= limit) begin
          rsp_o.done   = 1'b1;
          rsp_o.result = rev_q ? MISS_CHAR : {2'b00, MISS_CODE};
          state_d      = SR_IDLE;
        end else begin
          rd_vld_d = 1'b1;
          addr_d   = addr_q + 7'd1;
        end
      end
      default: state_d = SR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SR_IDLE;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SR_IDLE && req_i.start) begin
      rev_q <= req_i.reverse;
      key_q <= req_i.key;
    end
  end

endmodule

// ===== rtl/six_bit_codebook_text_packer.sv =====
// Top level of the six-bit codebook text packer: item sequencer, code groups, result queue.
// Depends on sbctp_pkg and sbctp_search.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one in_item_t per item; output channel
//   out_valid_o / out_stall_i carries one out_item_t per result, last_of_run on the final
//   result of an item. The config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes
//   codebook_size (index 0) and expand_mode (index 1); the user must write them only while
//   the block is idle; the block does not enforce this. One item at a time: in_stall_o is
//   high from acceptance until the last result of the item is loaded into the output
//   register, which then holds it while the next item runs. A load, an expand byte that does
//   not close a group, or a flush that emits nothing is handled in the idle state. A compress
//   data byte or flush runs one codebook search over up to N = min(codebook_size, 64)
//   entries at a miss, fewer on a hit, then pushes up to 3 codes and emits up to 3 results.
//   An expand byte that closes a group runs four searches, then emits up to 4 results.
//   The search engine reads one codebook entry per cycle; that read sets the rate.
//   When the receiver stalls, the output register holds and emission waits.
//   Reset clears both groups, sets codebook_size to 54 and compress mode; the codebook
//   itself is not cleared and must be loaded before lookups.
module six_bit_codebook_text_packer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sbctp_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sbctp_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sbctp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbctp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sbctp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_PUSH = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  function automatic logic [5:0] digit_of(input logic [23:0] w, input logic [1:0] k);
    logic [5:0] r;
    case (k)
      2'd0:    r = w[23:18];
      2'd1:    r = w[17:12];
      2'd2:    r = w[11:6];
      default: r = w[5:0];
    endcase
    return r;
  endfunction

  state_e      state_q, state_d;
  logic [6:0]  cb_size_q, cb_size_d;
  logic        expand_q, expand_d;
  logic [1:0]  slot_q, slot_d;
  logic [17:0] pcodes_q, pcodes_d;
  logic [1:0]  bcount_q, bcount_d;
  logic [15:0] pbytes_q, pbytes_d;
  logic [2:0]  res_cnt_q, res_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        start_q, start_d;
  logic        job_exp_q, job_exp_d;
  logic        job_flush_q, job_flush_d;
  logic [1:0]  push_left_q, push_left_d;
  logic [5:0]  look_q, look_d;
  logic [23:0] word_q, word_d;
  logic [1:0]  dig_q, dig_d;
  logic        brk_q, brk_d;
  logic [1:0]  emit_q, emit_d;
  logic [7:0]  key_q, key_d;
  logic        rev_q, rev_d;
  logic [7:0]  res_q [4];
  logic [7:0]  res_d [4];
  out_item_t   out_q, out_d;

  logic        accept;
  book_wr_t    book_wr;
  srch_req_t   srch_req;
  srch_rsp_t   srch_rsp;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign book_wr.we   = accept && (cmd_e'(in_data_i.command) == CMD_LOAD) &&
                        ({1'b0, in_data_i.entry_index} < 7'(BOOK_ENTRIES));
  assign book_wr.idx  = in_data_i.entry_index[BOOK_AW-1:0];
  assign book_wr.chr  = in_data_i.entry_char;
  assign book_wr.code = in_data_i.entry_code;

  assign srch_req.start   = start_q;
  assign srch_req.reverse = rev_q;
  assign srch_req.key     = key_q;

  sbctp_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cb_size_i (cb_size_q),
    .wr_i      (book_wr),
    .req_i     (srch_req),
    .rsp_o     (srch_rsp)
  );

  always_comb begin
    logic [7:0]  ch;
    logic [5:0]  code;
    logic [23:0] w;
    logic [2:0]  cnt;

    state_d     = state_q;
    cb_size_d   = cb_size_q;
    expand_d    = expand_q;
    slot_d      = slot_q;
    pcodes_d    = pcodes_q;
    bcount_d    = bcount_q;
    pbytes_d    = pbytes_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    start_d     = 1'b0;
    job_exp_d   = job_exp_q;
    job_flush_d = job_flush_q;
    push_left_d = push_left_q;
    look_d      = look_q;
    word_d      = word_q;
    dig_d       = dig_q;
    brk_d       = brk_q;
    emit_d      = emit_q;
    key_d       = key_q;
    rev_d       = rev_q;
    res_d       = res_q;
    out_d       = out_q;
    ch          = in_data_i.data_byte;
    code        = '0;
    w           = '0;
    cnt         = res_cnt_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CB_SIZE: cb_size_d = cfg_data_i;
        REG_EXPAND:  expand_d  = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_cnt_d = '0;
          job_exp_d = expand_q;
          case (cmd_e'(in_data_i.command))
            CMD_DATA: begin
              if (!expand_q) begin
                if (ch >= UPPER_LO && ch <= UPPER_HI) begin
                  key_d       = ch + CASE_OFFSET;
                  push_left_d = (slot_q == 2'd3) ? 2'd3 : 2'd2;
                end else begin
                  key_d       = ch;
                  push_left_d = 2'd1;
                end
                rev_d       = 1'b0;
                job_flush_d = 1'b0;
                start_d     = 1'b1;
                state_d     = ST_LOOK;
              end else if (bcount_q < 2'd2) begin
                pbytes_d = {pbytes_q[7:0], ch};
                bcount_d = bcount_q + 2'd1;
              end else begin
                word_d   = {pbytes_q, ch};
                pbytes_d = '0;
                bcount_d = '0;
                dig_d    = '0;
                brk_d    = 1'b0;
                key_d    = {2'b00, pbytes_q[15:10]};
                rev_d    = 1'b1;
                start_d  = 1'b1;
                state_d  = ST_LOOK;
              end
            end
            CMD_FLUSH: begin
              if (!expand_q) begin
                if (slot_q != 2'd0) begin
                  key_d       = '0;
                  rev_d       = 1'b0;
                  job_flush_d = 1'b1;
                  push_left_d = 2'(3'd4 - {1'b0, slot_q});
                  start_d     = 1'b1;
                  state_d     = ST_LOOK;
                end
              end else begin
                pbytes_d = '0;
                bcount_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (srch_rsp.done) begin
          if (!job_exp_q) begin
            look_d  = srch_rsp.result[5:0];
            state_d = ST_PUSH;
          end else begin
            if (brk_q) begin
              res_d[cnt[1:0]] = srch_rsp.result - CASE_OFFSET;
              cnt             = cnt + 3'd1;
              brk_d           = 1'b0;
            end else if (srch_rsp.result == BRACKET_CHAR) begin
              brk_d = 1'b1;
            end else begin
              res_d[cnt[1:0]] = srch_rsp.result;
              cnt             = cnt + 3'd1;
            end
            res_cnt_d = cnt;
            if (dig_q == 2'd3) begin
              emit_d  = '0;
              state_d = (cnt == 3'd0) ? ST_IDLE : ST_EMIT;
            end else begin
              dig_d   = dig_q + 2'd1;
              key_d   = {2'b00, digit_of(word_q, dig_q + 2'd1)};
              start_d = 1'b1;
            end
          end
        end
      end
      ST_PUSH: begin
        code = (job_flush_q || push_left_q == 2'd1) ? look_q : ESC_CODE;
        if (slot_q == 2'd3) begin
          w        = {pcodes_q, code};
          res_d[0] = w[23:16];
          res_d[1] = w[15:8];
          res_d[2] = w[7:0];
          cnt      = 3'd3;
          slot_d   = '0;
          pcodes_d = '0;
        end else begin
          pcodes_d = {pcodes_q[11:0], code};
          slot_d   = slot_q + 2'd1;
        end
        res_cnt_d   = cnt;
        push_left_d = push_left_q - 2'd1;
        if (push_left_q == 2'd1) begin
          emit_d  = '0;
          state_d = (cnt == 3'd0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.out_byte    = res_q[emit_q];
          out_d.last_of_run = (emit_q == 2'(res_cnt_q - 3'd1));
          out_valid_d       = 1'b1;
          emit_d            = emit_q + 2'd1;
          if (emit_q == 2'(res_cnt_q - 3'd1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cb_size_q   <= 7'd54;
      expand_q    <= 1'b0;
      slot_q      <= '0;
      pcodes_q    <= '0;
      bcount_q    <= '0;
      pbytes_q    <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
      job_exp_q   <= 1'b0;
      job_flush_q <= 1'b0;
      push_left_q <= '0;
      dig_q       <= '0;
      brk_q       <= 1'b0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      cb_size_q   <= cb_size_d;
      expand_q    <= expand_d;
      slot_q      <= slot_d;
      pcodes_q    <= pcodes_d;
      bcount_q    <= bcount_d;
      pbytes_q    <= pbytes_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      job_exp_q   <= job_exp_d;
      job_flush_q <= job_flush_d;
      push_left_q <= push_left_d;
      dig_q       <= dig_d;
      brk_q       <= brk_d;
      emit_q      <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    look_q <= look_d;
    word_q <= word_d;
    key_q  <= key_d;
    rev_q  <= rev_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_done_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> (state_q == ST_LOOK))
    else $error("search finished outside lookup");

  a_res_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (res_cnt_q != 3'd0 && res_cnt_q <= 3'd4))
    else $error("bad result count in emit");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == ST_LOOK) && $past(in_stall_o || accept))
    else $error("search started outside lookup");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for six_bit_codebook_text_packer: codebook loads, text packing and
// unpacking under random handshake pressure, checked against an in-line packer model.
// Depends on sbctp_pkg and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbctp_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [CFG_DATA_W-1:0] RESET_BOOK_SIZE = 7'd54;
  localparam logic [5:0] BRACKET_SLOT = 6'd27;
  localparam int PREDICT = -1;
  localparam int DRAIN_CYCLES = 300;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASE_ITEMS = 13;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    logic                  typed;
    logic [2:0]            n_typed;
    logic [31:0]           typed_bytes;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [7:0]            book_char [BOOK_ENTRIES];
  logic [5:0]            book_code [BOOK_ENTRIES];
  logic [1:0]            code_slot = '0;
  logic [17:0]           code_acc = '0;
  logic [1:0]            byte_slot = '0;
  logic [15:0]           byte_acc = '0;
  logic [CFG_DATA_W-1:0] book_size = RESET_BOOK_SIZE;
  logic                  expand_on = 1'b0;
  logic [7:0]            emitted [$];
  out_item_t             awaited [$];

  int errors = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 64;
  int idle_cycles = 0;
  int phase_size [6] = '{64, 7, 127, 0, 30, 54};
  int phase_mode [6] = '{0, 1, 0, 1, 1, 0};

  six_bit_codebook_text_packer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int search_span();
    return (book_size > BOOK_ENTRIES) ? BOOK_ENTRIES : int'(book_size);
  endfunction

  function automatic logic [5:0] code_for(logic [7:0] ch);
    logic [7:0] key;
    key = ch;
    if (ch >= UPPER_LO && ch <= UPPER_HI) key = ch + CASE_OFFSET;
    for (int j = 0; j < search_span(); j++) begin
      if (book_char[j] == key) return book_code[j];
    end
    return MISS_CODE;
  endfunction

  function automatic logic [7:0] char_for(logic [5:0] code);
    for (int j = 0; j < search_span(); j++) begin
      if (book_code[j] == code) return book_char[j];
    end
    return MISS_CHAR;
  endfunction

  function automatic void push_code(logic [5:0] code);
    logic [23:0] word;
    if (code_slot == 2'd3) begin
      word = {code_acc, code};
      emitted.push_back(word[23:16]);
      emitted.push_back(word[15:8]);
      emitted.push_back(word[7:0]);
      code_slot = '0;
      code_acc = '0;
    end else begin
      code_acc = {code_acc[11:0], code};
      code_slot = code_slot + 2'd1;
    end
  endfunction

  function automatic void run_packer(in_item_t it);
    logic [23:0] word;
    logic [7:0]  chars [4];
    logic [7:0]  shifted;
    logic [5:0]  pad;
    int          i;
    emitted.delete();
    case (it.command)
      CMD_LOAD: begin
        if (it.entry_index < BOOK_ENTRIES) begin
          book_char[it.entry_index] = it.entry_char;
          book_code[it.entry_index] = it.entry_code;
        end
      end
      CMD_DATA: begin
        if (!expand_on) begin
          if (it.data_byte >= UPPER_LO && it.data_byte <= UPPER_HI) begin
            if (code_slot == 2'd3) push_code(ESC_CODE);
            push_code(ESC_CODE);
          end
          push_code(code_for(it.data_byte));
        end else if (byte_slot < 2'd2) begin
          byte_acc = {byte_acc[7:0], it.data_byte};
          byte_slot = byte_slot + 2'd1;
        end else begin
          word = {byte_acc, it.data_byte};
          for (int c = 0; c < 4; c++) chars[c] = char_for(word[23-6*c -: 6]);
          i = 0;
          while (i < 4) begin
            if (chars[i] != BRACKET_CHAR) begin
              emitted.push_back(chars[i]);
            end else begin
              i++;
              if (i < 4) begin
                shifted = chars[i] - CASE_OFFSET;
                emitted.push_back(shifted);
              end
            end
            i++;
          end
          byte_slot = '0;
          byte_acc = '0;
        end
      end
      CMD_FLUSH: begin
        if (!expand_on) begin
          if (code_slot != 2'd0) begin
            pad = code_for(8'h00);
            while (emitted.size() == 0) push_code(pad);
          end
        end else begin
          byte_slot = '0;
          byte_acc = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t text_item();
    in_item_t it;
    int       r;
    it = in_item_t'($bits(in_item_t)'($urandom));
    r = $urandom_range(99);
    if (r < 8) it.command = CMD_LOAD;
    else if (r < 16) it.command = CMD_FLUSH;
    else if (r < 20) it.command = CMD_SPARE;
    else begin
      it.command = CMD_DATA;
      r = $urandom_range(99);
      if (r < 35) it.data_byte = 8'($urandom_range(8'h7A, 8'h61));
      else if (r < 60) it.data_byte = 8'($urandom_range(UPPER_HI, UPPER_LO));
      else if (r < 66) it.data_byte = BRACKET_CHAR;
      else if (r < 70) it.data_byte = ($urandom_range(1) != 0) ? 8'h40 : 8'h5B;
      else if (r < 75) it.data_byte = 8'h20;
      else if (r < 80) it.data_byte = 8'h00;
      else it.data_byte = 8'($urandom_range(255));
    end
    return it;
  endfunction

  function automatic logic [23:0] code_group();
    logic [23:0] word;
    int          r;
    word = '0;
    for (int c = 0; c < 4; c++) begin
      r = $urandom_range(99);
      if (r < 25) word = {word[17:0], book_code[BRACKET_SLOT]};
      else if (r < 85 && search_span() > 0)
        word = {word[17:0], book_code[$urandom_range(search_span() - 1)]};
      else word = {word[17:0], 6'($urandom_range(63))};
    end
    return word;
  endfunction

  function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t item_step(logic [1:0] cmd, logic [7:0] dbyte, int n_typed,
                                      logic [31:0] typed);
    step_t s;
    s = '0;
    s.item.command = cmd;
    s.item.data_byte = dbyte;
    if (n_typed >= 0) begin
      s.typed = 1'b1;
      s.n_typed = 3'(n_typed);
      s.typed_bytes = typed;
    end
    return s;
  endfunction

  task automatic send_item(in_item_t it, int n_typed, logic [31:0] typed);
    out_item_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    run_packer(it);
    if (n_typed >= 0) begin
      for (int k = 0; k < n_typed; k++) begin
        r.out_byte = typed[31-8*k -: 8];
        r.last_of_run = (k == n_typed - 1);
        awaited.push_back(r);
      end
    end else begin
      for (int k = 0; k < emitted.size(); k++) begin
        r.out_byte = emitted[k];
        r.last_of_run = (k == emitted.size() - 1);
        awaited.push_back(r);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CB_SIZE) book_size = val;
    else expand_on = val[0];
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("out_byte %02h arrived with no result expected", out_data.out_byte);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STUCK_LIMIT) begin
      $error("no item moved for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    in_item_t    it;
    step_t       s;
    step_t       script [$];
    logic [23:0] word;
    int          done_items;
    int          r;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int j = 0; j < BOOK_ENTRIES; j++) begin
      it = in_item_t'($bits(in_item_t)'($urandom));
      it.command = CMD_LOAD;
      it.entry_index = 6'(j);
      it.entry_code = 6'(j);
      if (j < 26) it.entry_char = 8'(8'h61 + j);
      else if (j == 26) it.entry_char = 8'h20;
      else if (j == BRACKET_SLOT) it.entry_char = BRACKET_CHAR;
      else if (j == 28) it.entry_char = 8'h00;
      else it.entry_char = 8'($urandom_range(255));
      send_item(it, PREDICT, '0);
    end

    script.push_back(cfg_step(REG_CB_SIZE, 7'd0));
    script.push_back(item_step(CMD_DATA, "x", 0, '0));
    script.push_back(item_step(CMD_DATA, 8'h00, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'hFF, 0, '0));
    script.push_back(item_step(CMD_DATA, "q", 3, 32'hD34D3400));
    script.push_back(item_step(CMD_DATA, 8'hFF, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'h00, 0, '0));
    script.push_back(item_step(CMD_DATA, "z", 0, '0));
    script.push_back(item_step(CMD_DATA, "A", 3, 32'hD34D3200));
    script.push_back(item_step(CMD_FLUSH, 8'h00, 3, 32'hCB4D3400));
    script.push_back(item_step(CMD_FLUSH, 8'h00, 0, '0));
    script.push_back(item_step(CMD_SPARE, 8'hFF, 0, '0));
    s = item_step(CMD_LOAD, 8'h00, 0, '0);
    s.item.entry_index = 6'd63;
    s.item.entry_char = 8'hFF;
    s.item.entry_code = 6'd63;
    script.push_back(s);
    script.push_back(cfg_step(REG_CB_SIZE, 7'd127));
    script.push_back(item_step(CMD_DATA, "Z", PREDICT, '0));
    script.push_back(item_step(CMD_DATA, "]", PREDICT, '0));
    script.push_back(item_step(CMD_DATA, "a", PREDICT, '0));
    script.push_back(item_step(CMD_DATA, "M", PREDICT, '0));
    script.push_back(item_step(CMD_FLUSH, 8'h00, PREDICT, '0));
    script.push_back(cfg_step(REG_EXPAND, 7'd1));
    script.push_back(item_step(CMD_DATA, 8'h6C, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'h06, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'hDB, PREDICT, '0));
    script.push_back(item_step(CMD_DATA, 8'h00, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'h10, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'h9B, PREDICT, '0));
    script.push_back(item_step(CMD_DATA, 8'h12, 0, '0));
    script.push_back(item_step(CMD_FLUSH, 8'h00, 0, '0));
    script.push_back(cfg_step(REG_CB_SIZE, 7'd0));
    script.push_back(item_step(CMD_DATA, 8'hFF, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'hFF, 0, '0));
    script.push_back(item_step(CMD_DATA, 8'hFF, 4, 32'h20202020));

    foreach (script[k]) begin
      if (script[k].is_cfg) write_reg(script[k].reg_idx, script[k].reg_val);
      else send_item(script[k].item, script[k].typed ? int'(script[k].n_typed) : PREDICT,
                     script[k].typed_bytes);
    end

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 14 : (p < 4) ? 64 : 0;
      recv_idle_pct = (p < 2) ? 64 : (p < 4) ? 14 : 0;
      write_reg(REG_CB_SIZE, CFG_DATA_W'(phase_size[p]));
      write_reg(REG_EXPAND, CFG_DATA_W'(phase_mode[p]));
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        if (!expand_on) begin
          it = text_item();
          send_item(it, PREDICT, '0);
          if (it.command != CMD_SPARE) done_items++;
        end else begin
          r = $urandom_range(99);
          if (r < 70) begin
            word = code_group();
            for (int b = 0; b < 3; b++) begin
              it = in_item_t'($bits(in_item_t)'($urandom));
              it.command = CMD_DATA;
              it.data_byte = word[23-8*b -: 8];
              send_item(it, PREDICT, '0);
            end
            done_items += 3;
          end else begin
            it = in_item_t'($bits(in_item_t)'($urandom));
            it.command = (r < 80) ? CMD_DATA : (r < 88) ? CMD_FLUSH :
                         (r < 96) ? CMD_LOAD : CMD_SPARE;
            send_item(it, PREDICT, '0);
            if (it.command != CMD_SPARE) done_items++;
          end
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbctp_pkg.sv
rtl/sbctp_search.sv
rtl/six_bit_codebook_text_packer.sv
test/testbench.sv
